FILE: hdl/b64c_pkg.sv
// Shared types, constants and alphabet functions for the base64 codec.
`timescale 1ns / 1ps

package b64c_pkg;

   // Pad character '='
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Job queue depth between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Mode register values
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // One group's worth of output bytes, first byte in bytes[0]
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;   // 0..4 valid bytes
   } job_type;

   // 6-bit value to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26)      r = 8'h41 + {2'b00, v};
      else if (v < 6'd52) r = 8'h61 + ({2'b00, v} - 8'd26);
      else if (v < 6'd62) r = 8'h30 + ({2'b00, v} - 8'd52);
      else if (v == 6'd62) r = 8'h2B;
      else                 r = 8'h2F;
      return r;
   endfunction

   // Alphabet character to 6-bit value, anything else is zero
   function automatic logic [5:0] dec_value(input logic [7:0] c);
      logic [7:0] r;
      if (c inside {[8'h41:8'h5A]})      r = c - 8'h41;
      else if (c inside {[8'h61:8'h7A]}) r = c - 8'h61 + 8'd26;
      else if (c inside {[8'h30:8'h39]}) r = c - 8'h30 + 8'd52;
      else if (c == 8'h2B)               r = 8'd62;
      else if (c == 8'h2F)               r = 8'd63;
      else                               r = 8'd0;
      return r[5:0];
   endfunction

endpackage

FILE: hdl/b64c_front.sv
// Front end: accepts input beats, tracks the group state and builds output jobs.
`timescale 1ns / 1ps

module b64c_front
   import b64c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_data,
   input  logic       req_last,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   logic        mode_ff, mode_in;
   logic [1:0]  phase_ff, phase_in;
   logic [20:0] held_ff, held_in;
   logic        accept;
   job_type     job;

   // decode-side helpers
   logic [5:0] v, a, bb, c;
   logic       pad;
   logic [2:0] fl;
   logic [2:0] pads;
   logic [7:0] b0, b1;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Group step: next state and job for the incoming beat
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      job      = '0;
      v        = dec_value(req_data);
      pad      = (req_data == PAD_CHAR);
      a        = held_ff[17:12];
      bb       = held_ff[11:6];
      c        = held_ff[5:0];
      fl       = held_ff[20:18];
      b0       = held_ff[15:8];
      b1       = held_ff[7:0];
      pads     = 3'd0;
      if (mode_ff == MODE_ENCODE) begin
         if (phase_ff == 2'd0) begin
            if (req_last) begin
               job.bytes[0] = enc_char(req_data[7:2]);
               job.bytes[1] = enc_char({req_data[1:0], 4'b0000});
               job.bytes[2] = PAD_CHAR;
               job.bytes[3] = PAD_CHAR;
               job.count    = 3'd4;
            end else begin
               held_in  = {13'd0, req_data};
               phase_in = 2'd1;
            end
         end else if (phase_ff == 2'd1) begin
            if (req_last) begin
               job.bytes[0] = enc_char(b1[7:2]);
               job.bytes[1] = enc_char({b1[1:0], req_data[7:4]});
               job.bytes[2] = enc_char({req_data[3:0], 2'b00});
               job.bytes[3] = PAD_CHAR;
               job.count    = 3'd4;
            end else begin
               held_in  = {5'd0, b1, req_data};
               phase_in = 2'd2;
            end
         end else begin
            job.bytes[0] = enc_char(b0[7:2]);
            job.bytes[1] = enc_char({b0[1:0], b1[7:4]});
            job.bytes[2] = enc_char({b1[3:0], req_data[7:6]});
            job.bytes[3] = enc_char(req_data[5:0]);
            job.count    = 3'd4;
            held_in      = '0;
            phase_in     = 2'd0;
         end
         if (req_last) begin
            held_in  = '0;
            phase_in = 2'd0;
         end
      end else begin
         if (phase_ff != 2'd3) begin
            held_in  = {fl[1:0], pad, held_ff[11:0], v};
            phase_in = phase_ff + 2'd1;
            if (req_last) begin
               held_in  = '0;
               phase_in = 2'd0;
            end
         end else begin
            // trailing pad run counted back from the fourth character
            if (req_last && pad) begin
               pads = 3'd1;
               if (fl[0]) begin
                  pads = 3'd2;
                  if (fl[1]) pads = 3'd3;
               end
            end
            job.bytes[0] = {a, bb[5:4]};
            job.bytes[1] = {bb[3:0], c[5:2]};
            job.bytes[2] = {c[1:0], v};
            job.count    = (pads >= 3'd3) ? 3'd0 : 3'd3 - pads;
            held_in      = '0;
            phase_in     = 2'd0;
         end
      end
   end

   assign q_push = accept && (job.count != 3'd0);
   assign q_job  = job;

   // Mode and group state registers
   always_comb begin
      mode_in = mode_ff;
      if (csr_wr_en) mode_in = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         phase_ff <= 2'd0;
         held_ff  <= '0;
      end else if (csr_wr_en) begin
         mode_ff  <= mode_in;
         phase_ff <= 2'd0;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   // Encode groups never hold more than two bytes
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ENCODE) |-> (phase_ff != 2'd3))
      else $error("encode phase out of range");

   // A final beat always leaves the group empty
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_last && !csr_wr_en) |=> (phase_ff == 2'd0))
      else $error("group not cleared after last beat");

   // A full encode group always produces four characters
   assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_ENCODE && phase_ff == 2'd2) |-> (job.count == 3'd4))
      else $error("encode group without four characters");

endmodule

FILE: hdl/b64c_queue.sv
// Short job queue decoupling the front end from the output serializer.
`timescale 1ns / 1ps

module b64c_queue
   import b64c_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job pushed into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("job popped from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.count != 3'd0 && push_job.count <= 3'd4))
      else $error("job with bad byte count");

endmodule

FILE: hdl/b64c_back.sv
// Back end: pulls jobs from the queue and sends their bytes one beat at a time.
`timescale 1ns / 1ps

module b64c_back
   import b64c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_data,
   output logic       rsp_last
);

   job_type    job_ff;
   logic       active_ff, active_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff;
   logic [7:0] out_data_ff;
   logic       out_last_ff;
   logic       adv;
   logic       final_byte;
   logic       fin;

   // Output register may load when empty or being drained
   assign adv        = !out_valid_ff || rsp_tready;
   assign final_byte = (({1'b0, idx_ff} + 3'd1) == job_ff.count);
   assign fin        = active_ff && adv && final_byte;
   assign q_pop      = !q_empty && (!active_ff || fin);

   // Job and byte index control
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (q_pop) begin
         active_in = 1'b1;
         idx_in    = 2'd0;
      end else if (fin) begin
         active_in = 1'b0;
      end else if (active_ff && adv) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         if (adv) out_valid_ff <= active_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= head_job;
      if (adv && active_ff) begin
         out_data_ff <= job_ff.bytes[idx_ff];
         out_last_ff <= final_byte;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_last   = out_last_ff;

   // An active job always has at least one byte left
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (job_ff.count != 3'd0 && {1'b0, idx_ff} < job_ff.count))
      else $error("serializer index beyond job");

   // Finishing a job with nothing queued leaves the serializer idle
   assert property (@(posedge clock) disable iff (reset)
      (fin && q_empty) |=> !active_ff)
      else $error("serializer did not go idle");

   // The final byte of a job is always flagged as the last beat
   assert property (@(posedge clock) disable iff (reset)
      (adv && active_ff && final_byte) |=> (rsp_tvalid && rsp_last))
      else $error("final byte not flagged");

endmodule

FILE: hdl/base64_codec.sv
// Top level of the streaming base64 encoder/decoder.
`timescale 1ns / 1ps

// Streaming base64 codec, standard alphabet with '=' padding. csr_wr_data
// selects encode (0) or decode (1); a write clears any partial group, so
// write it only between messages. Input beats carry a byte or character in
// req_tdata and mark the end of a message with req_tlast. Encoding turns
// every three bytes into four characters, flushing a padded group on tlast;
// decoding turns every quartet into up to three bytes and drops a partial
// trailing quartet. rsp_tlast flags the final beat of each output group.
// The front end takes one beat per cycle while the two-entry job queue
// has room; the output serializer sends at most one beat per cycle, so
// sustained rate is set by output bytes when encoding and by input
// characters when decoding.
module base64_codec
   import b64c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // decode_mode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] data_byte
   input  logic       req_tlast,     // last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast      // out_last
);

   logic    q_push, q_pop, q_full, q_empty;
   job_type push_job, head_job;

   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_data    (req_tdata),
      .req_last    (req_tlast),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   b64c_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   b64c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule
